@@ rtl/tccs_pkg.sv @@
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console: opcodes, register
// indexes, field widths and cell encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG    = 2'd0,
    CFG_BG    = 2'd1,
    CFG_SPARE = 2'd2,
    CFG_HIGH  = 2'd3
  } cfg_idx_t;

  // fixed field widths
  localparam int OPCODE_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 16;

  // character and cell codes
  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {BG_RESET, FG_RESET, BLANK_CODE};

endpackage

`default_nettype wire

@@ rtl/tccs_ram.sv @@
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on same-address access).
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rdata = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_scroll.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Character-cell text console with cursor, newline handling, scroll-up,
// clear and cell readback over a COLUMNS x ROWS cell memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per accepted item (valid high, stall low): put
//           character, clear screen, read cell or no-op.
//   out_* : exactly one result per request, in order, held while out_stall.
//   cfg_* : foreground/background color writes, always ready; write only
//           while no request is outstanding.
// Sequence (from accept to result register):
//   put character, read cell, no-op : execute state, then result register
//   put character that scrolls      : execute, scroll of (ROWS-1)*COLUMNS cells
//   clear screen                    : execute, fill of ROWS*COLUMNS cells
//   Scroll and clear are bound by the single write port of the cell memory,
//   one cell per cycle; a scroll reads and writes one cell each cycle.
// Reset: cursor to row 0 column 0, colors to 7/0, then a clearing pass over
//   all ROWS*COLUMNS cells writes every cell to 0x0720 with in_stall high.
// A stalled result stays in the output register; one more request can be
//   taken meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OPCODE_W-1:0]  in_opcode,
  input  wire logic [CHAR_W-1:0]    in_char_code,
  input  wire logic [ROW_OUT_W-1:0] in_read_row,
  input  wire logic [COL_OUT_W-1:0] in_read_column,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ROW_OUT_W-1:0]      out_cursor_row_now,
  output logic [COL_OUT_W-1:0]      out_cursor_column_now,
  output logic [CELL_W-1:0]         out_cell_value,
  output logic                      out_scrolled,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COLOR_W-1:0]   cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_LAST = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL,
    S_POST
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic              wb_v_r, wb_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // latched request and result payload
  op_t               op_r;
  logic [CHAR_W-1:0] ch_r;
  logic              rd_ok_r;
  logic [CELL_W-1:0] res_cell_r, res_cell_nxt;
  logic              res_scr_r, res_scr_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic [AW-1:0]     wb_addr_r, wb_addr_nxt;

  // output registers
  logic [ROW_OUT_W-1:0] out_row_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [CELL_W-1:0]    out_cell_r;
  logic                 out_scr_r;

  // configuration registers
  logic [COLOR_W-1:0] fg_r, bg_r;

  // memory port
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic          in_acc;
  logic          cfg_acc;
  logic          finish;
  logic          slot_free;
  logic          out_load;
  logic          wrap;
  logic [AW-1:0] in_rd_addr;
  logic          in_rd_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || !out_stall;

  // readback address, issued at accept so data is ready in the execute cycle
  assign in_rd_addr = AW'(32'(in_read_row) * COLUMNS + 32'(in_read_column));
  assign in_rd_ok   = (32'(in_read_row) < ROWS) && (32'(in_read_column) < COLUMNS);

  // cell memory
  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    scan_nxt     = scan_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    base_nxt     = base_r;
    res_cell_nxt = res_cell_r;
    res_scr_nxt  = res_scr_r;
    fill_val_nxt = fill_val_r;
    wb_v_nxt     = 1'b0;
    wb_addr_nxt  = scan_r;
    finish       = 1'b0;
    wrap         = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = base_r + AW'(col_r);
    mem_wdata    = {bg_r, fg_r, ch_r};
    mem_raddr    = in_rd_addr;

    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r;
        mem_wdata = RESET_CELL;
        if (scan_r == LAST_CELL) begin
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_cell_nxt = '0;
        res_scr_nxt  = 1'b0;
        case (op_r)
          OP_PUT: begin
            wrap = (ch_r == NEWLINE_CHAR) || (col_r == LAST_COL);
            // write the cell at the cursor unless newline
            mem_we = (ch_r != NEWLINE_CHAR);
            if (!wrap) begin
              col_nxt = col_r + 1'b1;
              finish  = 1'b1;
            end else begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                res_scr_nxt = 1'b1;
                scan_nxt    = '0;
                state_nxt   = S_SCROLL;
              end else begin
                row_nxt  = row_r + 1'b1;
                base_nxt = base_r + ROW_STEP;
                finish   = 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            fill_val_nxt = {bg_r, fg_r, BLANK_CODE};
            scan_nxt     = '0;
            state_nxt    = S_FILL;
          end
          OP_READ: begin
            res_cell_nxt = rd_ok_r ? mem_rdata : '0;
            finish       = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_SCROLL: begin
        // read one row down, write back next cycle
        mem_raddr   = scan_r + ROW_STEP;
        wb_v_nxt    = 1'b1;
        wb_addr_nxt = scan_r;
        if (scan_r == SCROLL_LAST) begin
          state_nxt = S_POST;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r;
        mem_wdata = fill_val_r;
        if (scan_r == LAST_CELL) begin
          state_nxt = S_POST;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_POST: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // scroll write-back takes the write port
    if (wb_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr_r;
      mem_wdata = mem_rdata;
    end

    // hand the result to the output register or wait for it
    out_load = 1'b0;
    if (finish) begin
      if (slot_free) begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_POST;
      end
    end
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      scan_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      wb_v_r      <= wb_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      op_r    <= op_t'(in_opcode);
      ch_r    <= in_char_code;
      rd_ok_r <= in_rd_ok;
    end
    res_cell_r <= res_cell_nxt;
    res_scr_r  <= res_scr_nxt;
    fill_val_r <= fill_val_nxt;
    wb_addr_r  <= wb_addr_nxt;
    if (out_load) begin
      out_row_r  <= ROW_OUT_W'(row_nxt);
      out_col_r  <= COL_OUT_W'(col_nxt);
      out_cell_r <= res_cell_nxt;
      out_scr_r  <= res_scr_nxt;
    end
  end

  // color registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_acc) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FG:  fg_r <= cfg_data;
        CFG_BG:  bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_cursor_row_now    = out_row_r;
  assign out_cursor_column_now = out_col_r;
  assign out_cell_value        = out_cell_r;
  assign out_scrolled          = out_scr_r;

`ifndef SYNTH
  // no scroll write-back may be pending when a request can be taken
  a_no_wb_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !wb_v_r)
    else $error("scroll write-back pending while idle");

  // a scrolled result leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |->
      (out_row_r == ROW_OUT_W'(ROWS - 1)) && (out_col_r == '0))
    else $error("scrolled result with cursor off the last row start");

  // a new result only comes from the execute or result-wait states
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_POST))
    else $error("result produced outside execute or wait state");

  // row base tracks the cursor row
  a_row_base: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == AW'(32'(row_r) * COLUMNS))
    else $error("row base out of step with cursor row");
`endif

endmodule

`default_nettype wire
